FILE: rtl/cdnw_pkg.sv
// Shared types and constants of the character-LCD nibble writer.
// Used by every module of the block; depends on nothing else.

package cdnw_pkg;

	// Request codes on the op port.
	typedef enum logic [2:0] {
		OP_CMD  = 3'd0,
		OP_CHAR = 3'd1,
		OP_POS  = 3'd2,
		OP_TWO  = 3'd3,
		OP_FOUR = 3'd4,
		OP_INIT = 3'd5
	} op_t;

	// DDRAM address of the first column of each display line.
	localparam logic [7:0] LINE1_BASE = 8'h80;
	localparam logic [7:0] LINE2_BASE = 8'hC0;
	localparam logic [7:0] LINE3_BASE = 8'h94;
	localparam logic [7:0] LINE4_BASE = 8'hD4;

	// Line numbers that select a base address.
	localparam logic [7:0] LINE_1 = 8'd1;
	localparam logic [7:0] LINE_2 = 8'd2;
	localparam logic [7:0] LINE_3 = 8'd3;
	localparam logic [7:0] LINE_4 = 8'd4;

	// Init sequence: a lone nibble that switches to 4-bit mode, then four commands.
	localparam logic [3:0] INIT_LEAD_NIBBLE = 4'h2;
	localparam logic [7:0] INIT_FUNCSET     = 8'h28;
	localparam logic [7:0] INIT_DISPLAY_ON  = 8'h0C;
	localparam logic [7:0] INIT_ENTRY_MODE  = 8'h06;
	localparam logic [7:0] INIT_CLEAR       = 8'h01;

	// High nibble of an ASCII decimal digit.
	localparam logic [3:0] ASCII_DIGIT_HI = 4'h3;

	// Reciprocal of ten: floor(n * RECIP_10 / 2**35) equals n / 10 for any 32-bit n.
	localparam logic [31:0] RECIP_10   = 32'hCCCCCCCD;
	localparam int          RECIP_SHIFT = 35;

	// Job queue between front and back.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// One classified request: up to four bytes with one register-select level,
	// optionally preceded by the lone init nibble.
	typedef struct packed {
		logic            rs;
		logic            lead;
		logic [1:0]      nbytes_m1;
		logic [3:0][7:0] bytes;
	} cdnw_job_t;

endpackage

FILE: rtl/cdnw_front.sv
// Front end of the nibble writer: accepts requests and turns them into jobs.
// Holds the iterative decimal digit unit. Depends on cdnw_pkg.

module cdnw_front import cdnw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [2:0]  op,
	input  logic [7:0]  byte_value,
	input  logic [7:0]  line,
	input  logic [7:0]  column,
	input  logic [31:0] number,
	input  logic        q_full,
	output logic        job_push,
	output cdnw_job_t   job
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_MUL   = 4'b0010,
		ST_SPLIT = 4'b0100,
		ST_DONE  = 4'b1000
	} dig_state_t;

	dig_state_t      state_q;
	logic [31:0]     n_q;
	logic [28:0]     prod_q;
	logic [1:0]      cnt_q;
	logic            four_q;
	logic [3:0][3:0] dig_q;

	op_t             op_c;
	logic            accept;
	logic [7:0]      pos_cmd;
	logic            direct_valid;
	cdnw_job_t       direct_job;
	cdnw_job_t       digit_job;
	logic [63:0]     product;
	logic [32:0]     tens;
	logic            last_digit;

	assign op_c   = op_t'(op);
	assign full   = q_full || (state_q != ST_IDLE);
	assign accept = push && !full;

	// Cursor command for a set-position request.
	always_comb begin
		unique case (line)
			LINE_1:  pos_cmd = LINE1_BASE + column - 8'd1;
			LINE_2:  pos_cmd = LINE2_BASE + column - 8'd1;
			LINE_3:  pos_cmd = LINE3_BASE + column - 8'd1;
			LINE_4:  pos_cmd = LINE4_BASE + column - 8'd1;
			default: pos_cmd = line;
		endcase
	end

	// Requests that become a job in the cycle they arrive.
	always_comb begin
		direct_valid = 1'b0;
		direct_job   = '0;
		unique case (op_c)
			OP_CMD: begin
				direct_valid           = 1'b1;
				direct_job.bytes[0]    = byte_value;
			end
			OP_CHAR: begin
				direct_valid           = 1'b1;
				direct_job.rs          = 1'b1;
				direct_job.bytes[0]    = byte_value;
			end
			OP_POS: begin
				direct_valid           = 1'b1;
				direct_job.bytes[0]    = pos_cmd;
			end
			OP_INIT: begin
				direct_valid           = 1'b1;
				direct_job.lead        = 1'b1;
				direct_job.nbytes_m1   = 2'd3;
				direct_job.bytes[0]    = INIT_FUNCSET;
				direct_job.bytes[1]    = INIT_DISPLAY_ON;
				direct_job.bytes[2]    = INIT_ENTRY_MODE;
				direct_job.bytes[3]    = INIT_CLEAR;
			end
			default: begin
				direct_valid = 1'b0;
			end
		endcase
	end

	// Digit job, most significant digit first.
	always_comb begin
		digit_job    = '0;
		digit_job.rs = 1'b1;
		if (four_q) begin
			digit_job.nbytes_m1 = 2'd3;
			digit_job.bytes[0]  = {ASCII_DIGIT_HI, dig_q[3]};
			digit_job.bytes[1]  = {ASCII_DIGIT_HI, dig_q[2]};
			digit_job.bytes[2]  = {ASCII_DIGIT_HI, dig_q[1]};
			digit_job.bytes[3]  = {ASCII_DIGIT_HI, dig_q[0]};
		end else begin
			digit_job.nbytes_m1 = 2'd1;
			digit_job.bytes[0]  = {ASCII_DIGIT_HI, dig_q[1]};
			digit_job.bytes[1]  = {ASCII_DIGIT_HI, dig_q[0]};
		end
	end

	// A finished digit job goes first; otherwise a direct job from the port.
	assign job_push = (state_q == ST_DONE) ? !q_full : (accept && direct_valid);
	assign job      = (state_q == ST_DONE) ? digit_job : direct_job;

	// Division by ten: a multiply state, then a state to form quotient and digit.
	assign product    = {32'd0, n_q} * {32'd0, RECIP_10};
	assign tens       = {1'b0, prod_q, 3'b000} + {3'b000, prod_q, 1'b0};
	assign last_digit = (cnt_q == (four_q ? 2'd3 : 2'd1));

	// Digit sequencer control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= 2'd0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept && (op_c == OP_TWO || op_c == OP_FOUR)) begin
						state_q <= ST_MUL;
						cnt_q   <= 2'd0;
					end
				end
				ST_MUL: begin
					state_q <= ST_SPLIT;
				end
				ST_SPLIT: begin
					if (last_digit) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_MUL;
						cnt_q   <= cnt_q + 2'd1;
					end
				end
				ST_DONE: begin
					if (!q_full) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Digit datapath.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept) begin
			n_q    <= number;
			four_q <= (op_c == OP_FOUR);
		end
		if (state_q == ST_MUL) begin
			prod_q <= product[63:RECIP_SHIFT];
		end
		if (state_q == ST_SPLIT) begin
			dig_q[cnt_q] <= n_q[3:0] - tens[3:0];
			n_q          <= {3'b000, prod_q};
		end
	end

endmodule

FILE: rtl/cdnw_queue.sv
// Short job queue that decouples the front end from the nibble sequencer.
// Depends on cdnw_pkg for the job type and the depth.

module cdnw_queue import cdnw_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      wr_en,
	input  cdnw_job_t wr_data,
	output logic      q_full,
	input  logic      rd_en,
	output cdnw_job_t rd_data,
	output logic      q_empty
);

	cdnw_job_t         mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign q_full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign q_empty = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !q_full)
		else $error("job written into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> !q_empty)
		else $error("job read from an empty queue");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("queue fill count beyond its depth");
`endif

endmodule

FILE: rtl/cdnw_back.sv
// Back end of the nibble writer: walks one job nibble by nibble into an
// output register read through empty and pop. Depends on cdnw_pkg.

module cdnw_back import cdnw_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_empty,
	input  cdnw_job_t  q_data,
	output logic       q_pop,
	output logic       empty,
	input  logic       pop,
	output logic       register_select,
	output logic [3:0] nibble,
	output logic       last
);

	cdnw_job_t  job_q;
	logic       job_valid_q;
	logic [3:0] idx_q;
	logic       out_valid_q;

	logic [3:0] total_m1;
	logic [3:0] k;
	logic [7:0] cur_byte;
	logic [3:0] cur_nibble;
	logic       is_last;
	logic       advance;

	// Nibble count of the job, less one: the lone nibble plus two per byte.
	assign total_m1 = {1'b0, job_q.nbytes_m1, 1'b0} + {3'b000, job_q.lead} + 4'd1;
	assign is_last  = (idx_q == total_m1);
	assign k        = idx_q - {3'b000, job_q.lead};
	assign cur_byte = job_q.bytes[k[2:1]];

	// The lone init nibble comes first; each byte goes out high nibble first.
	always_comb begin
		if (job_q.lead && idx_q == 4'd0) begin
			cur_nibble = INIT_LEAD_NIBBLE;
		end else if (k[0]) begin
			cur_nibble = cur_byte[3:0];
		end else begin
			cur_nibble = cur_byte[7:4];
		end
	end

	// A nibble moves whenever the output register is free or being emptied.
	assign advance = job_valid_q && (!out_valid_q || pop);
	assign q_pop   = !q_empty && (!job_valid_q || (advance && is_last));
	assign empty   = !out_valid_q;

	// Job and output control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_q <= 1'b0;
			idx_q       <= 4'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				job_valid_q <= 1'b1;
				idx_q       <= 4'd0;
			end else if (advance) begin
				if (is_last) begin
					job_valid_q <= 1'b0;
					idx_q       <= 4'd0;
				end else begin
					idx_q <= idx_q + 4'd1;
				end
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Job holding register and output payload.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_q <= q_data;
		end
		if (advance) begin
			register_select <= job_q.rs;
			nibble          <= cur_nibble;
			last            <= is_last;
		end
	end

endmodule

FILE: rtl/char_lcd_nibble_writer.sv
// Character-LCD 4-bit nibble writer, top level. Uses cdnw_pkg, cdnw_front,
// cdnw_queue and cdnw_back.
// Path: a byte, position or init request passes the queue entry, the job holding
// register and the output register; a digit request passes the digit states first.
// Throughput: one nibble per cycle from the back end while pop keeps pace; a request
// is 2 to 9 nibbles, and a digit request keeps the front busy until its job is queued.
// Reset: arst_n clears the queue, the digit sequencer and the output register.

module char_lcd_nibble_writer import cdnw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [2:0]  op,
	input  logic [7:0]  byte_value,
	input  logic [7:0]  line,
	input  logic [7:0]  column,
	input  logic [31:0] number,
	output logic        empty,
	input  logic        pop,
	output logic        register_select,
	output logic [3:0]  nibble,
	output logic        last
);

	logic      q_full;
	logic      q_empty;
	logic      job_push;
	logic      job_pop;
	cdnw_job_t job_in;
	cdnw_job_t job_out;

	// Request classification and digit conversion.
	cdnw_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.op         (op),
		.byte_value (byte_value),
		.line       (line),
		.column     (column),
		.number     (number),
		.q_full     (q_full),
		.job_push   (job_push),
		.job        (job_in)
	);

	// Jobs waiting for the nibble sequencer.
	cdnw_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (job_push),
		.wr_data (job_in),
		.q_full  (q_full),
		.rd_en   (job_pop),
		.rd_data (job_out),
		.q_empty (q_empty)
	);

	// Nibble sequencing and result register.
	cdnw_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_empty         (q_empty),
		.q_data          (job_out),
		.q_pop           (job_pop),
		.empty           (empty),
		.pop             (pop),
		.register_select (register_select),
		.nibble          (nibble),
		.last            (last)
	);

endmodule
